// ----- hw/rtl/csp_pkg.sv -----
// Shared widths, codes and types of the check sampling policy block.
package csp_pkg;

  localparam int TIME_W   = 32;
  localparam int TOTAL_W  = 64;
  localparam int CNT_W    = 32;
  localparam int CD_W     = 17;
  localparam int PV_W     = 16;
  localparam int LFSR_W   = 16;
  localparam int PCT_W    = 7;
  localparam int MASK_W   = 4;
  localparam int MODE_W   = 3;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SCALED_W = TIME_W + PCT_W;
  localparam int WIDE_W   = TOTAL_W + PCT_W;

  localparam int QDEPTH   = 2;
  localparam int PTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Ratio tests compare SCALE * time against total * percent.
  localparam int SCALE    = 100;
  localparam int PCT_MIN  = 1;
  localparam int PCT_MAX  = 99;

  localparam logic ACT_ADD_TIME = 1'b0;
  localparam logic ACT_REQUEST  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_NEVER    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALWAYS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BUDGET   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TIMING   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RANDOM   = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd3;

  // Configuration the front end needs to classify an item.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [PCT_W-1:0]  pct;
  } front_cfg_t;

  // One classified item on its way from the front end to the back end.
  typedef struct packed {
    logic                action;
    logic                enabled;
    logic [TIME_W-1:0]   ct;
    logic [TIME_W-1:0]   rt;
    logic [SCALED_W-1:0] ct100;
    logic [SCALED_W-1:0] prt;
  } op_t;

endpackage

// ----- hw/rtl/csp_front.sv -----
// Front end: accepts items, applies the kind mask and forms the scaled times.
module csp_front (
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       action,
  input  logic [csp_pkg::KIND_W-1:0] clause_kind,
  input  logic [csp_pkg::TIME_W-1:0] clause_time,
  input  logic [csp_pkg::TIME_W-1:0] routine_time,
  input  csp_pkg::front_cfg_t        fcfg,
  input  logic                       q_full,
  output logic                       push,
  output csp_pkg::op_t               push_op
);
  import csp_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_op.action  = action;
    push_op.enabled = fcfg.mask[clause_kind];
    push_op.ct      = clause_time;
    push_op.rt      = routine_time;
    push_op.ct100   = clause_time * SCALED_W'(SCALE);
    push_op.prt     = routine_time * fcfg.pct;
  end

endmodule

// ----- hw/rtl/csp_queue.sv -----
// Short queue of classified items between the front end and the back end.
module csp_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  csp_pkg::op_t push_op,
  output logic         q_full,
  input  logic         pop,
  output logic         head_valid,
  output csp_pkg::op_t head_op
);
  import csp_pkg::*;

  op_t               entries [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign q_full     = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/csp_back.sv -----
// Back end: policy state, configuration registers, decision and result register.
module csp_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  csp_pkg::op_t                  head_op,
  output logic                          pop,
  output csp_pkg::front_cfg_t           fcfg,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csp_pkg::PV_W-1:0]      cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          check_now,
  output logic [csp_pkg::CNT_W-1:0]     requests_seen,
  output logic [csp_pkg::CNT_W-1:0]     checks_allowed,
  output logic [csp_pkg::CD_W-1:0]      countdown_now
);
  import csp_pkg::*;

  typedef struct packed {
    logic [CD_W-1:0]   cd;
    logic [PV_W-1:0]   ws;
    logic [LFSR_W-1:0] lfsr;
  } rearm_t;

  localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;
  localparam logic [31:0]        DRAW_BIAS = 32'd65534;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [WIDE_W-1:0]  CHK_SCALED_MAX =
      {PCT_W'(SCALE), {TOTAL_W{1'b0}}} - WIDE_W'(SCALE);

  // Config registers.
  logic [MASK_W-1:0] mask, mask_next;
  logic [MODE_W-1:0] mode, mode_next;
  logic [PV_W-1:0]   pv, pv_next;
  logic [PCT_W-1:0]  pct, pct_next;
  logic [WIDE_W-1:0] pmax, pmax_next;
  // Policy state. chk100 and rtp track SCALE * check total and pct * routine total.
  logic [CNT_W-1:0]   req_cnt, req_cnt_next;
  logic [CNT_W-1:0]   alw_cnt, alw_cnt_next;
  logic [CD_W-1:0]    countdown, countdown_next;
  logic [PV_W-1:0]    ws, ws_next;
  logic [TOTAL_W-1:0] chk_tot, chk_tot_next;
  logic [TOTAL_W-1:0] rt_tot, rt_tot_next;
  logic [WIDE_W-1:0]  chk100, chk100_next;
  logic [WIDE_W-1:0]  rtp, rtp_next;
  logic [LFSR_W-1:0]  lfsr, lfsr_next;
  logic               run;

  logic               cfg_fire;
  logic [TOTAL_W:0]   rt_sum, ct_sum;
  logic [WIDE_W:0]    budget_lhs;
  logic               budget_ok, timing_ok;
  logic [MODE_W-1:0]  cfg_mode_sel;
  logic [PV_W-1:0]    cfg_pv_sel;
  logic [PCT_W-1:0]   cfg_pct;
  logic [WIDE_W-1:0]  cfg_rtp;
  rearm_t             item_re, cfg_re;

  function automatic logic [PCT_W-1:0] clamp_pct(input logic [PV_W-1:0] v);
    if (v < PV_W'(PCT_MIN)) begin
      clamp_pct = PCT_W'(PCT_MIN);
    end else if (v > PV_W'(PCT_MAX)) begin
      clamp_pct = PCT_W'(PCT_MAX);
    end else begin
      clamp_pct = v[PCT_W-1:0];
    end
  endfunction

  // Periodic mode reloads the interval; random mode steps the LFSR and
  // splits the window into a draw and the skip carried to the next window.
  function automatic rearm_t rearm(input logic [MODE_W-1:0] m,
                                   input logic [PV_W-1:0]   pv_i,
                                   input logic [LFSR_W-1:0] l,
                                   input logic [PV_W-1:0]   ws_i,
                                   input logic [CD_W-1:0]   cd_i);
    rearm_t      r;
    logic [LFSR_W-1:0] n;
    logic [31:0] x;
    logic [32:0] q_full;
    logic [PV_W-1:0] draw;
    r.cd   = cd_i;
    r.ws   = ws_i;
    r.lfsr = l;
    if (m == MODE_PERIODIC) begin
      r.cd = CD_W'(pv_i);
      r.ws = '0;
    end else if (m == MODE_RANDOM) begin
      n = {1'b0, l[LFSR_W-1:1]} ^ (l[0] ? LFSR_TAPS : '0);
      if (n == '0) begin
        n = LFSR_W'(1);
      end
      x = ({16'b0, n} * {16'b0, pv_i}) + DRAW_BIAS;
      // Exact floor(x / 65535) for any x below 65536 * 65535.
      q_full = {1'b0, x} + {17'b0, x[31:16]} + 33'd1;
      draw = q_full[31:16];
      if (draw > pv_i) begin
        draw = pv_i;
      end
      r.cd   = CD_W'(ws_i) + CD_W'(draw);
      r.ws   = pv_i - draw;
      r.lfsr = n;
    end
    rearm = r;
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign pop       = head_valid && (!out_valid || out_ready);
  assign fcfg.mask = mask;
  assign fcfg.pct  = pct;

  assign cfg_mode_sel = (cfg_index == CFG_MODE) ? cfg_data[MODE_W-1:0] : mode;
  assign cfg_pv_sel   = (cfg_index == CFG_POLICY) ? cfg_data : pv;
  assign cfg_pct      = clamp_pct(cfg_data);
  assign cfg_rtp      = rt_tot * cfg_pct;

  always_comb begin
    rt_sum     = {1'b0, rt_tot} + (TOTAL_W + 1)'(head_op.rt);
    ct_sum     = {1'b0, chk_tot} + (TOTAL_W + 1)'(head_op.ct);
    budget_lhs = {1'b0, chk100} + (WIDE_W + 1)'(head_op.ct100);
    budget_ok  = budget_lhs <= {1'b0, rtp};
    // A check of time zero or one still runs while the totals stay under budget.
    timing_ok  = (head_op.ct100 <= head_op.prt) ||
                 ((head_op.ct <= TIME_W'(1)) && (chk100 < rtp));
    item_re    = rearm(mode, pv, lfsr, ws, countdown);
    cfg_re     = rearm(cfg_mode_sel, cfg_pv_sel, lfsr, '0, countdown);

    mask_next      = mask;
    mode_next      = mode;
    pv_next        = pv;
    pct_next       = pct;
    pmax_next      = pmax;
    req_cnt_next   = req_cnt;
    alw_cnt_next   = alw_cnt;
    countdown_next = countdown;
    ws_next        = ws;
    chk_tot_next   = chk_tot;
    rt_tot_next    = rt_tot;
    chk100_next    = chk100;
    rtp_next       = rtp;
    lfsr_next      = lfsr;
    run            = 1'b0;

    if (pop) begin
      if (head_op.action == ACT_ADD_TIME) begin
        if (rt_sum[TOTAL_W]) begin
          rt_tot_next = TOTAL_MAX;
          rtp_next    = pmax;
        end else begin
          rt_tot_next = rt_sum[TOTAL_W-1:0];
          rtp_next    = rtp + WIDE_W'(head_op.prt);
        end
      end else begin
        if (req_cnt != CNT_MAX) begin
          req_cnt_next = req_cnt + 1'b1;
        end
        if (head_op.enabled) begin
          case (mode)
            MODE_ALWAYS: run = 1'b1;
            MODE_BUDGET: run = budget_ok;
            MODE_TIMING: run = timing_ok;
            MODE_PERIODIC, MODE_RANDOM: begin
              if (countdown > CD_W'(1)) begin
                countdown_next = countdown - 1'b1;
              end else begin
                run            = 1'b1;
                countdown_next = item_re.cd;
                ws_next        = item_re.ws;
                lfsr_next      = item_re.lfsr;
              end
            end
            default: run = 1'b0;
          endcase
        end
        if (run) begin
          if (alw_cnt != CNT_MAX) begin
            alw_cnt_next = alw_cnt + 1'b1;
          end
          if (ct_sum[TOTAL_W]) begin
            chk_tot_next = TOTAL_MAX;
            chk100_next  = CHK_SCALED_MAX;
          end else begin
            chk_tot_next = ct_sum[TOTAL_W-1:0];
            chk100_next  = chk100 + WIDE_W'(head_op.ct100);
          end
        end
      end
    end

    if (cfg_fire) begin
      case (cfg_index)
        CFG_MASK: mask_next = cfg_data[MASK_W-1:0];
        CFG_MODE: begin
          mode_next      = cfg_data[MODE_W-1:0];
          countdown_next = cfg_re.cd;
          ws_next        = cfg_re.ws;
          lfsr_next      = cfg_re.lfsr;
        end
        CFG_POLICY: begin
          pv_next        = cfg_data;
          pct_next       = cfg_pct;
          pmax_next      = {cfg_pct, {TOTAL_W{1'b0}}} - WIDE_W'(cfg_pct);
          rtp_next       = cfg_rtp;
          countdown_next = cfg_re.cd;
          ws_next        = cfg_re.ws;
          lfsr_next      = cfg_re.lfsr;
        end
        CFG_SEED: lfsr_next = (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
        default: mask_next = mask;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= {MASK_W{1'b1}};
      mode      <= MODE_ALWAYS;
      pv        <= '0;
      pct       <= PCT_W'(PCT_MIN);
      pmax      <= {PCT_W'(PCT_MIN), {TOTAL_W{1'b0}}} - WIDE_W'(PCT_MIN);
      req_cnt   <= '0;
      alw_cnt   <= '0;
      countdown <= '0;
      ws        <= '0;
      chk_tot   <= '0;
      rt_tot    <= '0;
      chk100    <= '0;
      rtp       <= '0;
      lfsr      <= LFSR_W'(1);
      out_valid <= 1'b0;
    end else begin
      mask      <= mask_next;
      mode      <= mode_next;
      pv        <= pv_next;
      pct       <= pct_next;
      pmax      <= pmax_next;
      req_cnt   <= req_cnt_next;
      alw_cnt   <= alw_cnt_next;
      countdown <= countdown_next;
      ws        <= ws_next;
      chk_tot   <= chk_tot_next;
      rt_tot    <= rt_tot_next;
      chk100    <= chk100_next;
      rtp       <= rtp_next;
      lfsr      <= lfsr_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result beat registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      check_now      <= run;
      requests_seen  <= req_cnt_next;
      checks_allowed <= alw_cnt_next;
      countdown_now  <= countdown_next;
    end
  end

endmodule

// ----- hw/rtl/check_sampling_policy.sv -----
// Top level of the check sampling policy block.
// Each input beat either adds a routine time estimate or asks whether a check of
// one of four clause kinds should run, and gives exactly one result beat. The
// block takes one beat per cycle while the receiver takes results: the front end
// masks and scales the item combinationally into a registered two-entry queue,
// and the back end decides and updates all policy state together and registers
// the result. The queue and the result register let either side stall on its
// own. Configuration writes belong to idle periods; there is no clearing pass.
module check_sampling_policy (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [csp_pkg::KIND_W-1:0]    clause_kind,
  input  logic [csp_pkg::TIME_W-1:0]    clause_time,
  input  logic [csp_pkg::TIME_W-1:0]    routine_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          check_now,
  output logic [csp_pkg::CNT_W-1:0]     requests_seen,
  output logic [csp_pkg::CNT_W-1:0]     checks_allowed,
  output logic [csp_pkg::CD_W-1:0]      countdown_now,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csp_pkg::PV_W-1:0]      cfg_data
);
  import csp_pkg::*;

  front_cfg_t fcfg;
  logic       q_full;
  logic       push;
  op_t        push_op;
  logic       pop;
  logic       q_head_valid;
  op_t        head_op;

  csp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .clause_kind  (clause_kind),
    .clause_time  (clause_time),
    .routine_time (routine_time),
    .fcfg         (fcfg),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  csp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .q_full     (q_full),
    .pop        (pop),
    .head_valid (q_head_valid),
    .head_op    (head_op)
  );

  csp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (q_head_valid),
    .head_op        (head_op),
    .pop            (pop),
    .fcfg           (fcfg),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .check_now      (check_now),
    .requests_seen  (requests_seen),
    .checks_allowed (checks_allowed),
    .countdown_now  (countdown_now)
  );

  // Input stalls only when the queue holds work for the back end.
  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_head_valid)
    else $error("input stalled with an empty queue");

  // Admitted checks never outnumber requests.
  a_allowed_le_seen: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (checks_allowed <= requests_seen))
    else $error("checks_allowed exceeds requests_seen");

  // A taken result with nothing queued leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !q_head_valid) |=> !out_valid)
    else $error("result repeated after it was taken");

endmodule

// ----- tb/csp_checker.sv -----
// Checker for the check sampling policy block: predicts each result beat and compares it.
module csp_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          action,
  input  logic [csp_pkg::KIND_W-1:0]    clause_kind,
  input  logic [csp_pkg::TIME_W-1:0]    clause_time,
  input  logic [csp_pkg::TIME_W-1:0]    routine_time,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          check_now,
  input  logic [csp_pkg::CNT_W-1:0]     requests_seen,
  input  logic [csp_pkg::CNT_W-1:0]     checks_allowed,
  input  logic [csp_pkg::CD_W-1:0]      countdown_now,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [csp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [csp_pkg::PV_W-1:0]      cfg_data,
  output int                            pending,
  output int                            errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import csp_pkg::*;

  localparam int PROD_W = TOTAL_W + 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam int DRAW_DIV = 65535;

  typedef struct packed {
    logic             run;
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] allowed;
    logic [CD_W-1:0]  cd;
  } decision_t;

  decision_t decision_q[$];

  logic [MASK_W-1:0]  mask_r;
  logic [MODE_W-1:0]  mode_r;
  logic [PV_W-1:0]    policy_r;
  logic [LFSR_W-1:0]  lfsr_r;
  logic [CNT_W-1:0]   req_cnt;
  logic [CNT_W-1:0]   adm_cnt;
  logic [CD_W-1:0]    countdown_r;
  logic [PV_W-1:0]    skip_r;
  logic [TOTAL_W-1:0] check_sum;
  logic [TOTAL_W-1:0] routine_sum;

  function automatic logic [TOTAL_W-1:0] add_sat(logic [TOTAL_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + b;
    return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [PCT_W-1:0] overhead_pct();
    if (policy_r < PCT_MIN) return PCT_W'(PCT_MIN);
    if (policy_r > PCT_MAX) return PCT_W'(PCT_MAX);
    return policy_r[PCT_W-1:0];
  endfunction

  // Reload the countdown: the interval in periodic mode, a fresh window draw in random mode.
  function automatic void rearm();
    logic        lsb;
    logic [39:0] prod;
    logic [39:0] draw;
    if (mode_r == MODE_PERIODIC) begin
      countdown_r = CD_W'(policy_r);
      skip_r = '0;
    end else if (mode_r == MODE_RANDOM) begin
      lsb = lfsr_r[0];
      lfsr_r = lfsr_r >> 1;
      if (lsb) lfsr_r = lfsr_r ^ LFSR_TAPS;
      if (lfsr_r == '0) lfsr_r = LFSR_W'(1);
      prod = 40'(lfsr_r) * 40'(policy_r) + 40'(DRAW_DIV - 1);
      draw = prod / 40'(DRAW_DIV);
      if (draw > 40'(policy_r)) draw = 40'(policy_r);
      countdown_r = CD_W'({1'b0, skip_r}) + CD_W'(draw);
      skip_r = policy_r - PV_W'(draw);
    end
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [PV_W-1:0] data);
    case (idx)
      CFG_MASK: begin
        mask_r = data[MASK_W-1:0];
      end
      CFG_MODE: begin
        mode_r = data[MODE_W-1:0];
        skip_r = '0;
        rearm();
      end
      CFG_POLICY: begin
        policy_r = data;
        skip_r = '0;
        rearm();
      end
      default: begin
        lfsr_r = (data == '0) ? LFSR_W'(1) : data;
      end
    endcase
  endfunction

  function automatic logic admit(logic [TIME_W-1:0] ct, logic [TIME_W-1:0] rt);
    logic [TOTAL_W:0]   s;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;
    logic [PCT_W-1:0]   p;
    p = overhead_pct();
    case (mode_r)
      MODE_ALWAYS: return 1'b1;
      MODE_BUDGET: begin
        s = {1'b0, check_sum} + ct;
        lhs = PROD_W'(s) * PROD_W'(SCALE);
        rhs = PROD_W'(routine_sum) * PROD_W'(p);
        return lhs <= rhs;
      end
      MODE_TIMING: begin
        lhs = PROD_W'(ct) * PROD_W'(SCALE);
        rhs = PROD_W'(rt) * PROD_W'(p);
        if (lhs <= rhs) return 1'b1;
        // Near-free checks fall back to the running totals, strictly under budget.
        if (ct <= 1) begin
          lhs = PROD_W'(check_sum) * PROD_W'(SCALE);
          rhs = PROD_W'(routine_sum) * PROD_W'(p);
          return lhs < rhs;
        end
        return 1'b0;
      end
      MODE_PERIODIC, MODE_RANDOM: begin
        if (countdown_r > 1) begin
          countdown_r = countdown_r - 1'b1;
          return 1'b0;
        end
        rearm();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic decision_t predict_decision(logic act, logic [KIND_W-1:0] kind,
                                                 logic [TIME_W-1:0] ct, logic [TIME_W-1:0] rt);
    decision_t d;
    d.run = 1'b0;
    if (act == ACT_ADD_TIME) begin
      routine_sum = add_sat(routine_sum, rt);
    end else begin
      if (req_cnt != '1) req_cnt = req_cnt + 1;
      if (mask_r[kind]) begin
        d.run = admit(ct, rt);
        if (d.run) begin
          if (adm_cnt != '1) adm_cnt = adm_cnt + 1;
          check_sum = add_sat(check_sum, ct);
        end
      end
    end
    d.seen = req_cnt;
    d.allowed = adm_cnt;
    d.cd = countdown_r;
    return d;
  endfunction

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (rst) begin
      mask_r = 4'hF;
      mode_r = MODE_ALWAYS;
      policy_r = '0;
      lfsr_r = LFSR_W'(1);
      req_cnt = '0;
      adm_cnt = '0;
      countdown_r = '0;
      skip_r = '0;
      check_sum = '0;
      routine_sum = '0;
      decision_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_cfg(cfg_index, cfg_data);
      // Results leave before this edge's input beat could add one of its own.
      if (out_valid && out_ready) begin
        if (decision_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with no expected result, check_now %0d requests %0h",
                   $time, check_now, requests_seen);
        end else begin
          want = decision_q.pop_front();
          if (check_now !== want.run) report("check_now", 64'(want.run), 64'(check_now));
          if (requests_seen !== want.seen)
            report("requests_seen", 64'(want.seen), 64'(requests_seen));
          if (checks_allowed !== want.allowed)
            report("checks_allowed", 64'(want.allowed), 64'(checks_allowed));
          if (countdown_now !== want.cd)
            report("countdown_now", 64'(want.cd), 64'(countdown_now));
        end
      end
      if (in_valid && in_ready)
        decision_q.push_back(predict_decision(action, clause_kind, clause_time, routine_time));
      pending <= decision_q.size();
    end
  end

endmodule

// ----- tb/tb_check_sampling_policy.sv -----
// Testbench top for the check sampling policy block: stimulus, back-pressure and verdict.
module tb_check_sampling_policy;
  timeunit 1ns;
  timeprecision 1ps;
  import csp_pkg::*;

  localparam int RANDOM_ITEMS = 550;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 10;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef enum {RX_OPEN, RX_RANDOM, RX_THIRDS, RX_STALLS} rx_pattern_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 action = ACT_ADD_TIME;
  logic [KIND_W-1:0]    clause_kind = '0;
  logic [TIME_W-1:0]    clause_time = '0;
  logic [TIME_W-1:0]    routine_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 check_now;
  logic [CNT_W-1:0]     requests_seen;
  logic [CNT_W-1:0]     checks_allowed;
  logic [CD_W-1:0]      countdown_now;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MASK;
  logic [PV_W-1:0]      cfg_data = '0;
  int                   pending;
  int                   errors;
  int                   burst_left = 0;
  int                   idle_cycles = 0;
  rx_pattern_t          rx_pattern = RX_OPEN;
  int                   rx_left = 0;
  int                   stall_run = 0;

  check_sampling_policy dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .clause_kind(clause_kind),
    .clause_time(clause_time), .routine_time(routine_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .check_now(check_now), .requests_seen(requests_seen),
    .checks_allowed(checks_allowed), .countdown_now(countdown_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  csp_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .clause_kind(clause_kind),
    .clause_time(clause_time), .routine_time(routine_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .check_now(check_now), .requests_seen(requests_seen),
    .checks_allowed(checks_allowed), .countdown_now(countdown_now),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .errors(errors)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: the pattern is drawn again each time its run ends.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 64);
    end else begin
      rx_left--;
    end
    case (rx_pattern)
      RX_OPEN: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 7);
      RX_THIRDS: out_ready <= (rx_left % 3 == 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_ready <= 1'b0;
        end else begin
          if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(2, 10);
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("check_sampling_policy test failed");
      $finish;
    end
  end

  // Holds cfg_valid high; the caller lowers it after its last write.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [PV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // The seed goes before the mode and policy writes so that a re-arm from either draws from it.
  task automatic set_config(logic [MASK_W-1:0] mask, logic [MODE_W-1:0] mode,
                            logic [PV_W-1:0] policy, logic [PV_W-1:0] seed);
    cfg_write(CFG_MASK, PV_W'(mask));
    cfg_write(CFG_SEED, seed);
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(CFG_MODE, PV_W'(mode));
      cfg_write(CFG_POLICY, policy);
    end else begin
      cfg_write(CFG_POLICY, policy);
      cfg_write(CFG_MODE, PV_W'(mode));
    end
    cfg_valid <= 1'b0;
  endtask

  // Lower valid and hold off until the last result beat has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_item(logic act, logic [KIND_W-1:0] kind,
                           logic [TIME_W-1:0] ct, logic [TIME_W-1:0] rt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    action <= act;
    clause_kind <= kind;
    clause_time <= ct;
    routine_time <= rt;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_item();
    logic              act;
    logic [TIME_W-1:0] ct;
    logic [TIME_W-1:0] rt;
    act = ($urandom_range(0, 9) < 7) ? ACT_REQUEST : ACT_ADD_TIME;
    case ($urandom_range(0, 9))
      0: begin
        ct = $urandom_range(0, 1);
        rt = $urandom;
      end
      1: begin
        ct = '1;
        rt = ($urandom_range(0, 1) == 0) ? '1 : $urandom;
      end
      2, 3: begin
        ct = $urandom;
        rt = $urandom;
      end
      default: begin
        ct = $urandom_range(0, 2000);
        rt = $urandom_range(0, 4000);
      end
    endcase
    send_item(act, KIND_W'($urandom_range(0, 3)), ct, rt);
  endtask

  function automatic logic [PV_W-1:0] pick_policy(logic [MODE_W-1:0] mode);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return PV_W'(SCALE);
        2: return '1;
        default: return PV_W'($urandom);
      endcase
    end
    if (mode == MODE_PERIODIC || mode == MODE_RANDOM) return PV_W'($urandom_range(0, 12));
    return PV_W'($urandom_range(1, 120));
  endfunction

  initial begin
    logic [MODE_W-1:0] mode;
    logic [MASK_W-1:0] mask;
    logic [PV_W-1:0]   seed;
    int                sent;
    int                n;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings admit every request.
    send_item(ACT_ADD_TIME, 2'd0, '0, '1);
    send_item(ACT_ADD_TIME, 2'd1, '1, '0);
    send_item(ACT_REQUEST, 2'd0, '0, '0);
    send_item(ACT_REQUEST, 2'd3, '1, '1);
    drain();

    // Timing with a zero percent (clamped up), a masked-off kind and the near-free fallback.
    set_config(4'b0101, MODE_TIMING, '0, 16'd1);
    send_item(ACT_REQUEST, 2'd1, '0, '0);
    send_item(ACT_REQUEST, 2'd0, '0, '0);
    send_item(ACT_REQUEST, 2'd2, 32'd1, '0);
    send_item(ACT_REQUEST, 2'd0, 32'd2, 32'd200);
    send_item(ACT_REQUEST, 2'd2, '1, '1);
    drain();

    // Budget with an over-range percent, clamped down.
    set_config(4'hF, MODE_BUDGET, PV_W'(SCALE), 16'd1);
    send_item(ACT_REQUEST, 2'd1, 32'd5, '0);
    send_item(ACT_REQUEST, 2'd3, '1, '0);
    drain();

    // Periodic from a zero countdown, then an interval of two.
    set_config(4'hF, MODE_PERIODIC, '0, 16'd1);
    send_item(ACT_REQUEST, 2'd0, 32'd3, 32'd3);
    send_item(ACT_REQUEST, 2'd1, 32'd3, 32'd3);
    drain();
    set_config(4'hF, MODE_PERIODIC, 16'd2, 16'd1);
    send_item(ACT_REQUEST, 2'd2, 32'd7, 32'd9);
    send_item(ACT_REQUEST, 2'd3, 32'd7, 32'd9);
    send_item(ACT_REQUEST, 2'd0, 32'd7, 32'd9);
    drain();

    // Random window from a zero seed, which loads as one.
    set_config(4'b1110, MODE_RANDOM, 16'd3, '0);
    send_item(ACT_REQUEST, 2'd0, 32'd1, 32'd1);
    send_item(ACT_REQUEST, 2'd1, 32'd1, 32'd1);
    send_item(ACT_REQUEST, 2'd2, 32'd1, 32'd1);
    send_item(ACT_REQUEST, 2'd3, 32'd1, 32'd1);
    drain();

    // Unused modes and never admit nothing.
    set_config(4'hF, MODE_UNUSED_LO, '1, '1);
    send_item(ACT_REQUEST, 2'd0, '0, '1);
    drain();
    set_config(4'hF, MODE_UNUSED_HI, '1, '1);
    send_item(ACT_REQUEST, 2'd1, '0, '1);
    drain();
    set_config(4'hF, MODE_NEVER, '0, '1);
    send_item(ACT_REQUEST, 2'd2, '0, '1);
    drain();

    // Random phases, each under fresh settings.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 10))
        0: mode = MODE_NEVER;
        1: mode = MODE_ALWAYS;
        2, 3: mode = MODE_BUDGET;
        4, 5: mode = MODE_TIMING;
        6, 7: mode = MODE_PERIODIC;
        8, 9: mode = MODE_RANDOM;
        default: mode = ($urandom_range(0, 1) == 0) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
      endcase
      mask = ($urandom_range(0, 2) == 0) ? MASK_W'($urandom_range(0, 15)) : 4'hF;
      case ($urandom_range(0, 7))
        0: seed = '0;
        1: seed = '1;
        default: seed = PV_W'($urandom_range(1, 65535));
      endcase
      set_config(mask, mode, pick_policy(mode), seed);
      n = $urandom_range(12, 32);
      repeat (n) send_random_item();
      sent += n;
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("check_sampling_policy test passed");
    end else begin
      $display("check_sampling_policy test failed");
    end
    $finish;
  end

endmodule
